// ----- hdl/pfa_pkg.sv -----
package pfa_pkg;

    // table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 20;
    localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

    // fixed field widths of the ports
    localparam int OP_W       = 1;
    localparam int BIDX_W     = 4;
    localparam int AMT_W      = 20;
    localparam int POL_W      = 2;
    localparam int BCNT_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // input operation codes
    localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
    localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    typedef enum logic [POL_W-1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_NEXT  = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    // settings in effect, as seen by the scan sequencer
    typedef struct packed {
        policy_t             policy;
        logic [CNT_BITS-1:0] count;
    } cfg_t;

    // table access from the sequencer
    typedef struct packed {
        logic                 we;
        logic [IDX_BITS-1:0]  waddr;
        logic [SIZE_BITS-1:0] wdata;
        logic                 re;
        logic [IDX_BITS-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        logic                 granted;
        logic [BIDX_W-1:0]    block;
        logic [AMT_W-1:0]     remaining;
    } result_t;

endpackage

// ----- hdl/partition_fit_allocator_core.sv -----
// channel   direction  handshake            payload
// cfg       in         cfg_write            cfg_index, cfg_data
// input     in         in_valid / in_stall  op, block_index, amount, last_request
// result    out        out_valid / out_stall granted, chosen_block, remaining_after
//
// a load is written to the size table on transfer and gives no result; a request runs
// the transfer, one size-table read per block in effect over the single read port
// (first and next fit stop at the first fit), and the write-back state, which also
// hands the result to the output register.
// rst_n clears control state only; the size table holds nothing until loaded.
// a stalled result holds the write-back cycle; the next item waits until it is taken.
module partition_fit_allocator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pfa_pkg::OP_W-1:0]          op,
    input  logic [pfa_pkg::BIDX_W-1:0]        block_index,
    input  logic [pfa_pkg::AMT_W-1:0]         amount,
    input  logic                              last_request,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              granted,
    output logic [pfa_pkg::BIDX_W-1:0]        chosen_block,
    output logic [pfa_pkg::AMT_W-1:0]         remaining_after
);

    localparam int CW = pfa_pkg::CNT_BITS;

    pfa_pkg::policy_t               policy_reg, policy_next;
    logic [pfa_pkg::BCNT_W-1:0]     count_reg, count_next;
    pfa_pkg::cfg_t                  cfg;

    pfa_pkg::mem_req_t              mem_req;
    logic [pfa_pkg::SIZE_BITS-1:0]  rd_data;
    logic                           res_valid;
    pfa_pkg::result_t               res;
    logic                           res_take;

    logic                           out_valid_reg, out_valid_next;
    pfa_pkg::result_t               out_reg;

    // configuration writes
    always_comb
    begin
        policy_next = policy_reg;
        count_next  = count_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                pfa_pkg::CFG_FIT_POLICY:
                    policy_next = pfa_pkg::policy_t'(cfg_data[pfa_pkg::POL_W-1:0]);
                pfa_pkg::CFG_BLOCK_COUNT:
                    count_next  = cfg_data[pfa_pkg::BCNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= pfa_pkg::POL_FIRST;
            count_reg  <= pfa_pkg::BCNT_W'(1);
        end
        else
        begin
            policy_reg <= policy_next;
            count_reg  <= count_next;
        end
    end

    // block count in effect, clamped to one .. table depth
    always_comb
    begin
        cfg.policy = policy_reg;
        priority if (count_reg == '0)
        begin
            cfg.count = CW'(1);
        end
        else if (int'(count_reg) > pfa_pkg::NUM_BLOCKS)
        begin
            cfg.count = CW'(pfa_pkg::NUM_BLOCKS);
        end
        else
        begin
            cfg.count = CW'(count_reg);
        end
    end

    pfa_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .block_index  (block_index),
        .amount       (amount),
        .last_request (last_request),
        .mem_req      (mem_req),
        .rd_data      (rd_data),
        .res_valid    (res_valid),
        .res          (res),
        .res_take     (res_take)
    );

    pfa_size_mem #(
        .DEPTH  (pfa_pkg::NUM_BLOCKS),
        .ADDR_W (pfa_pkg::IDX_BITS),
        .DATA_W (pfa_pkg::SIZE_BITS)
    ) u_size_mem (
        .clk     (clk),
        .we      (mem_req.we),
        .waddr   (mem_req.waddr),
        .wdata   (mem_req.wdata),
        .re      (mem_req.re),
        .raddr   (mem_req.raddr),
        .rd_data (rd_data)
    );

    // output register: free when empty or its transfer completes
    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign granted         = out_reg.granted;
    assign chosen_block    = out_reg.block;
    assign remaining_after = out_reg.remaining;

endmodule

// ----- hdl/pfa_size_mem.sv -----
module pfa_size_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 20
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/pfa_scan.sv -----
module pfa_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfa_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pfa_pkg::OP_W-1:0]      op,
    input  logic [pfa_pkg::BIDX_W-1:0]    block_index,
    input  logic [pfa_pkg::AMT_W-1:0]     amount,
    input  logic                          last_request,
    output pfa_pkg::mem_req_t             mem_req,
    input  logic [pfa_pkg::SIZE_BITS-1:0] rd_data,
    output logic                          res_valid,
    output pfa_pkg::result_t              res,
    input  logic                          res_take
);

    localparam int IW = pfa_pkg::IDX_BITS;
    localparam int CW = pfa_pkg::CNT_BITS;
    localparam int SW = pfa_pkg::SIZE_BITS;

    pfa_pkg::state_t state_reg, state_next;

    logic [IW-1:0] pos_reg, pos_next;
    logic [IW-1:0] iss_addr_reg, iss_addr_next;
    logic [CW-1:0] iss_cnt_reg, iss_cnt_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [IW-1:0] chk_addr_reg, chk_addr_next;
    logic [CW-1:0] chk_cnt_reg, chk_cnt_next;
    logic          found_reg, found_next;
    logic [IW-1:0] pick_reg, pick_next;
    logic [SW-1:0] best_reg, best_next;
    logic [SW-1:0] amt_reg, amt_next;
    logic          last_reg, last_next;

    logic          accept;
    logic          is_load;
    logic          load_in_range;
    logic [IW-1:0] start_pos;
    logic          fits;
    logic          better;
    logic          take_new;
    logic          stop_now;
    logic          last_chk;
    logic          scan_done;
    logic          rd_issue;
    logic [SW-1:0] left_size;
    logic          finish;

    // handshake and input decode
    assign in_stall      = (state_reg != pfa_pkg::ST_IDLE);
    assign accept        = in_valid && !in_stall;
    assign is_load       = (op == pfa_pkg::OP_LOAD);
    assign load_in_range = (int'(block_index) < pfa_pkg::NUM_BLOCKS);

    // stale next-fit position restarts at block 0
    assign start_pos = (CW'(pos_reg) < cfg.count) ? pos_reg : '0;

    // compare of the entry read in the previous cycle
    assign fits = (rd_data >= amt_reg);

    always_comb
    begin
        unique case (cfg.policy)
            pfa_pkg::POL_BEST:  better = (rd_data < best_reg);
            pfa_pkg::POL_WORST: better = (rd_data > best_reg);
            default:            better = 1'b0;
        endcase
    end

    assign take_new  = chk_valid_reg && fits && (!found_reg || better);
    assign stop_now  = chk_valid_reg && fits &&
                       ((cfg.policy == pfa_pkg::POL_FIRST) ||
                        (cfg.policy == pfa_pkg::POL_NEXT));
    assign last_chk  = chk_valid_reg && ((chk_cnt_reg + CW'(1)) == cfg.count);
    assign scan_done = stop_now || last_chk;
    assign rd_issue  = (state_reg == pfa_pkg::ST_SCAN) && (iss_cnt_reg < cfg.count);
    assign left_size = best_reg - amt_reg;
    assign finish    = (state_reg == pfa_pkg::ST_WRITE) && res_take;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfa_pkg::ST_IDLE:
            begin
                if (accept && !is_load)
                begin
                    state_next = pfa_pkg::ST_SCAN;
                end
            end
            pfa_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = pfa_pkg::ST_WRITE;
                end
            end
            pfa_pkg::ST_WRITE:
            begin
                if (res_take)
                begin
                    state_next = pfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfa_pkg::ST_IDLE;
            end
        endcase
    end

    // table access and result outputs
    always_comb
    begin
        mem_req       = '0;
        res_valid     = 1'b0;
        res           = '0;
        mem_req.re    = rd_issue;
        mem_req.raddr = iss_addr_reg;
        unique case (state_reg)
            pfa_pkg::ST_IDLE:
            begin
                mem_req.we    = accept && is_load && load_in_range;
                mem_req.waddr = IW'(block_index);
                mem_req.wdata = SW'(amount);
            end
            pfa_pkg::ST_WRITE:
            begin
                res_valid     = 1'b1;
                res.granted   = found_reg;
                res.block     = found_reg ? pfa_pkg::BIDX_W'(pick_reg) : '0;
                res.remaining = found_reg ? pfa_pkg::AMT_W'(left_size) : '0;
                mem_req.we    = found_reg && res_take;
                mem_req.waddr = pick_reg;
                mem_req.wdata = left_size;
            end
            default:
            begin
            end
        endcase
    end

    // scan datapath
    always_comb
    begin
        iss_addr_next  = iss_addr_reg;
        iss_cnt_next   = iss_cnt_reg;
        chk_valid_next = 1'b0;
        chk_addr_next  = iss_addr_reg;
        chk_cnt_next   = chk_cnt_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        best_next      = best_reg;
        amt_next       = amt_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;

        // request transfer: latch operands, start at the first block to read
        if (accept && !is_load)
        begin
            amt_next      = SW'(amount);
            last_next     = last_request;
            iss_addr_next = (cfg.policy == pfa_pkg::POL_NEXT) ? start_pos : '0;
            iss_cnt_next  = '0;
            chk_cnt_next  = '0;
            found_next    = 1'b0;
        end

        // one read issued per cycle, wrapping at the block count
        if (rd_issue)
        begin
            chk_valid_next = 1'b1;
            iss_cnt_next   = iss_cnt_reg + CW'(1);
            if ((CW'(iss_addr_reg) + CW'(1)) == cfg.count)
            begin
                iss_addr_next = '0;
            end
            else
            begin
                iss_addr_next = iss_addr_reg + IW'(1);
            end
        end

        // candidate tracking
        if ((state_reg == pfa_pkg::ST_SCAN) && chk_valid_reg)
        begin
            chk_cnt_next = chk_cnt_reg + CW'(1);
            if (take_new)
            begin
                found_next = 1'b1;
                pick_next  = chk_addr_reg;
                best_next  = rd_data;
            end
        end

        // next-fit position update once the result is handed over; a last request resets it to block 0
        if (finish)
        begin
            if (found_reg && (cfg.policy == pfa_pkg::POL_NEXT))
            begin
                if ((CW'(pick_reg) + CW'(1)) < cfg.count)
                begin
                    pos_next = pick_reg + IW'(1);
                end
                else
                begin
                    pos_next = '0;
                end
            end
            if (last_reg)
            begin
                pos_next = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfa_pkg::ST_IDLE;
            pos_reg       <= '0;
            chk_valid_reg <= 1'b0;
            iss_cnt_reg   <= '0;
            chk_cnt_reg   <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            chk_valid_reg <= chk_valid_next;
            iss_cnt_reg   <= iss_cnt_next;
            chk_cnt_reg   <= chk_cnt_next;
            found_reg     <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        iss_addr_reg <= iss_addr_next;
        chk_addr_reg <= chk_addr_next;
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        amt_reg      <= amt_next;
        last_reg     <= last_next;
    end

endmodule
